// File: hw/rtl/fct_pkg.sv
// Shared types and constants for the frustum cull test block.
package fct_pkg;

   // Number of frustum planes held in configuration
   localparam int unsigned PLANE_COUNT = 6;

   // Width of the configuration register index and data
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 64;

   // Configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PLANE_NEAR   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PLANE_FAR    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PLANE_LEFT   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PLANE_RIGHT  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PLANE_TOP    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PLANE_BOTTOM = 3'd5;

   // Test kinds; the unused code falls to the cube test
   localparam int unsigned CMD_WIDTH = 2;
   localparam logic [CMD_WIDTH-1:0] CMD_POINT  = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_SPHERE = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_CUBE   = 2'd2;

   // Coefficient and radius formats
   localparam int unsigned COEF_WIDTH   = 16;   // a, b, c Q1.14 and d Q11.4
   localparam int unsigned RADIUS_WIDTH = 15;   // Q11.4, unsigned
   localparam int unsigned FRAC_SHIFT   = 14;   // Q.4 to Q.18
   localparam int unsigned ABS_WIDTH    = COEF_WIDTH + 1;        // |a|+|b|+|c|
   localparam int unsigned RTERM_WIDTH  = RADIUS_WIDTH + ABS_WIDTH;
   localparam int unsigned DSH_WIDTH    = COEF_WIDTH + FRAC_SHIFT;

   // One plane as packed in its configuration register
   typedef struct packed {
      logic signed [COEF_WIDTH-1:0] d;
      logic signed [COEF_WIDTH-1:0] c;
      logic signed [COEF_WIDTH-1:0] b;
      logic signed [COEF_WIDTH-1:0] a;
   } plane_type;

endpackage

// File: hw/rtl/frustum_cull_test_core.sv
// Frustum cull test core: four-stage pipeline testing shapes against six planes.
//
//   channel   direction  handshake                 payload
//   req       in         req_valid / req_stall     req_cmd, req_pos_x/y/z, req_radius
//   rsp       out        rsp_valid / rsp_stall     rsp_inside_res
//   csr       in         csr_wr_en                 csr_index, csr_wr_data
//
// One word per cycle while rsp is not stalled; a word's result is registered
// through stages 1 to 4 in order and is shown on rsp from stage 4.
// Stage 1 registers the word, stage 2 forms the plane products, stage 3 the
// plane distances and radius terms, stage 4 the per-plane compare and result.
// Reset clears the valid bits and the six plane registers to zero.
// A stall on rsp fills the bubbles first; req_stall rises only with every stage full.
module frustum_cull_test_core #(
   parameter int unsigned COORD_WIDTH = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // Request channel
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic [fct_pkg::CMD_WIDTH-1:0]             req_cmd,
   input  logic signed [COORD_WIDTH-1:0]             req_pos_x,
   input  logic signed [COORD_WIDTH-1:0]             req_pos_y,
   input  logic signed [COORD_WIDTH-1:0]             req_pos_z,
   input  logic [fct_pkg::RADIUS_WIDTH-1:0]          req_radius,
   // Response channel
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic                                      rsp_inside_res,
   // Configuration write port
   input  logic                                      csr_wr_en,
   input  logic [fct_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [fct_pkg::CSR_DATA_WIDTH-1:0]        csr_wr_data
);

   localparam int unsigned NP     = fct_pkg::PLANE_COUNT;
   localparam int unsigned CW     = fct_pkg::COEF_WIDTH;
   localparam int unsigned RW     = fct_pkg::RADIUS_WIDTH;
   localparam int unsigned PW     = CW + COORD_WIDTH;          // one product
   localparam int unsigned DW     = ((PW > fct_pkg::DSH_WIDTH) ? PW : fct_pkg::DSH_WIDTH) + 3;
   localparam int unsigned CMPW   = ((DW > fct_pkg::RTERM_WIDTH + 1) ? DW
                                     : fct_pkg::RTERM_WIDTH + 1) + 1;

   // Plane registers
   fct_pkg::plane_type plane_ff [NP];

   // Stage valid bits and advance enables
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   // Stage 1 payload
   logic [fct_pkg::CMD_WIDTH-1:0] cmd1_ff;
   logic signed [COORD_WIDTH-1:0] x1_ff, y1_ff, z1_ff;
   logic [RW-1:0]                 r1_ff;

   // Stage 2 payload
   logic [fct_pkg::CMD_WIDTH-1:0]       cmd2_ff;
   logic [RW-1:0]                       r2_ff;
   logic signed [PW-1:0]                px_ff [NP], px_in [NP];
   logic signed [PW-1:0]                py_ff [NP], py_in [NP];
   logic signed [PW-1:0]                pz_ff [NP], pz_in [NP];
   logic signed [fct_pkg::DSH_WIDTH-1:0] dsh_ff [NP], dsh_in [NP];
   logic [fct_pkg::ABS_WIDTH-1:0]       abs_ff [NP], abs_in [NP];

   // Stage 3 payload
   logic [fct_pkg::CMD_WIDTH-1:0]        cmd3_ff;
   logic [RW-1:0]                        r3_ff;
   logic signed [DW-1:0]                 dist_ff [NP], dist_in [NP];
   logic [fct_pkg::RTERM_WIDTH-1:0]      rterm_ff [NP], rterm_in [NP];

   // Stage 4 payload
   logic inside4_ff, inside4_in;

   // Ready chain: a stage takes a word when empty or when it passes its own on
   assign rdy4 = !v4_ff || !rsp_stall;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_stall = !rdy1;

   // Write plane registers; ignore indexes beyond the bottom plane
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NP; i++) begin
            plane_ff[i] <= '0;
         end
      end else if (csr_wr_en) begin
         case (csr_index)
            fct_pkg::CSR_PLANE_NEAR:   plane_ff[0] <= fct_pkg::plane_type'(csr_wr_data);
            fct_pkg::CSR_PLANE_FAR:    plane_ff[1] <= fct_pkg::plane_type'(csr_wr_data);
            fct_pkg::CSR_PLANE_LEFT:   plane_ff[2] <= fct_pkg::plane_type'(csr_wr_data);
            fct_pkg::CSR_PLANE_RIGHT:  plane_ff[3] <= fct_pkg::plane_type'(csr_wr_data);
            fct_pkg::CSR_PLANE_TOP:    plane_ff[4] <= fct_pkg::plane_type'(csr_wr_data);
            fct_pkg::CSR_PLANE_BOTTOM: plane_ff[5] <= fct_pkg::plane_type'(csr_wr_data);
            default: begin
            end
         endcase
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // Stage 1: capture the request word
   always_ff @(posedge clock) begin
      if (rdy1) begin
         cmd1_ff <= req_cmd;
         x1_ff   <= req_pos_x;
         y1_ff   <= req_pos_y;
         z1_ff   <= req_pos_z;
         r1_ff   <= req_radius;
      end
   end

   // Stage 2: coefficient products, shifted offset and coefficient magnitudes
   always_comb begin
      logic [CW:0] abs_a, abs_b, abs_c;
      for (int i = 0; i < NP; i++) begin
         px_in[i]  = PW'(plane_ff[i].a) * PW'(x1_ff);
         py_in[i]  = PW'(plane_ff[i].b) * PW'(y1_ff);
         pz_in[i]  = PW'(plane_ff[i].c) * PW'(z1_ff);
         dsh_in[i] = {plane_ff[i].d, {fct_pkg::FRAC_SHIFT{1'b0}}};
         abs_a = plane_ff[i].a[CW-1] ? -(CW+1)'(plane_ff[i].a) : (CW+1)'(plane_ff[i].a);
         abs_b = plane_ff[i].b[CW-1] ? -(CW+1)'(plane_ff[i].b) : (CW+1)'(plane_ff[i].b);
         abs_c = plane_ff[i].c[CW-1] ? -(CW+1)'(plane_ff[i].c) : (CW+1)'(plane_ff[i].c);
         abs_in[i] = fct_pkg::ABS_WIDTH'(abs_a[CW-1:0]) + fct_pkg::ABS_WIDTH'(abs_b[CW-1:0])
                   + fct_pkg::ABS_WIDTH'(abs_c[CW-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         cmd2_ff <= cmd1_ff;
         r2_ff   <= r1_ff;
         for (int i = 0; i < NP; i++) begin
            px_ff[i]  <= px_in[i];
            py_ff[i]  <= py_in[i];
            pz_ff[i]  <= pz_in[i];
            dsh_ff[i] <= dsh_in[i];
            abs_ff[i] <= abs_in[i];
         end
      end
   end

   // Stage 3: plane distances in Q.18 and the cube radius terms
   always_comb begin
      for (int i = 0; i < NP; i++) begin
         dist_in[i]  = DW'(px_ff[i]) + DW'(py_ff[i]) + DW'(pz_ff[i]) + DW'(dsh_ff[i]);
         rterm_in[i] = fct_pkg::RTERM_WIDTH'(r2_ff) * fct_pkg::RTERM_WIDTH'(abs_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         cmd3_ff <= cmd2_ff;
         r3_ff   <= r2_ff;
         for (int i = 0; i < NP; i++) begin
            dist_ff[i]  <= dist_in[i];
            rterm_ff[i] <= rterm_in[i];
         end
      end
   end

   // Stage 4: per-plane cull test, then drop the shape if any plane culls it
   always_comb begin
      logic signed [CMPW-1:0] dist_ext, rsh_ext, rt_ext, sph_sum, cube_sum;
      logic                   culled;
      inside4_in = 1'b1;
      for (int i = 0; i < NP; i++) begin
         dist_ext = CMPW'(dist_ff[i]);
         rsh_ext  = CMPW'({r3_ff, {fct_pkg::FRAC_SHIFT{1'b0}}});
         rt_ext   = CMPW'(rterm_ff[i]);
         sph_sum  = dist_ext + rsh_ext;
         cube_sum = dist_ext + rt_ext;
         case (cmd3_ff)
            fct_pkg::CMD_POINT:  culled = dist_ext[CMPW-1] || (dist_ext == '0);
            fct_pkg::CMD_SPHERE: culled = sph_sum[CMPW-1] || (sph_sum == '0);
            default:             culled = cube_sum[CMPW-1];
         endcase
         if (culled) inside4_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         inside4_ff <= inside4_in;
      end
   end

   assign rsp_valid      = v4_ff;
   assign rsp_inside_res = inside4_ff;

endmodule

// File: hw/rtl/fct_checker.sv
// Port-level checker for the frustum cull test core, with its bind.
module fct_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_inside_res
);

   logic req_take;
   assign req_take = req_valid && !req_stall;

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_inside_res))
      else $error("stalled result word changed or vanished");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

   // With the output free, every stage can advance, so requests are taken
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while response side is free");

   // Free cycles without a request drain every stage of the pipeline
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (!req_take && !rsp_stall) ##1 (!req_take && !rsp_stall)
      ##1 (!req_take && !rsp_stall) ##1 (!req_take && !rsp_stall) |=> !rsp_valid)
      else $error("result word appeared without a request");

endmodule

bind frustum_cull_test_core fct_checker u_fct_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_inside_res (rsp_inside_res)
);
